// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, quiet during reset.
`define PLI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, quiet during reset.
`define PLI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/pli_pkg.sv =====
// ----------------------------------------------------------------------------
// pli_pkg
// Types and constants shared by the positional list modules.
// ----------------------------------------------------------------------------
package pli_pkg;

    localparam int DEPTH   = 16;
    localparam int ADDR_W  = 4;
    localparam int CNT_W   = 5;
    localparam int WORD_W  = 32;
    localparam int OP_W    = 3;
    localparam int POS_W   = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_LAST  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_DEL_FIRST = 3'd3,
        OP_DEL_LAST  = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_READ_AT   = 3'd6
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_WR,
        ST_DN_RD,
        ST_DN_WR,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]          opcode;
        logic signed [WORD_W-1:0] item_value;
        logic [POS_W-1:0]         position;
    } t_in_beat;

    typedef struct packed {
        logic                     ok;
        logic [CNT_W-1:0]         entry_total;
        logic signed [WORD_W-1:0] read_value;
    } t_out_beat;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage

// ===== src/pli_ram.sv =====
// ----------------------------------------------------------------------------
// pli_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/pli_seq.sv =====
// ----------------------------------------------------------------------------
// pli_seq
// Operation sequencer: decodes one beat, then walks the shift one entry at a
// time through a shared index stepper and the RAM ports.
// ----------------------------------------------------------------------------
module pli_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  pli_pkg::t_in_beat             i_item,
    input  logic                          i_out_free,
    input  logic [pli_pkg::WORD_W-1:0]    i_rdata,
    output logic                          o_busy,
    output pli_pkg::t_ram_req             o_ram,
    output logic                          o_res_valid,
    output pli_pkg::t_out_beat            o_res
);

    localparam logic [pli_pkg::CNT_W-1:0] CNT_FULL = pli_pkg::CNT_W'(pli_pkg::DEPTH);
    localparam logic [pli_pkg::CNT_W-1:0] CNT_ONE  = pli_pkg::CNT_W'(1);

    pli_pkg::t_state              r_state, n_state;
    logic [pli_pkg::CNT_W-1:0]    r_count, n_count;
    logic [pli_pkg::CNT_W-1:0]    r_idx,   n_idx;
    logic [pli_pkg::CNT_W-1:0]    r_slot,  n_slot;
    logic [pli_pkg::WORD_W-1:0]   r_word,  n_word;
    logic                         r_ok,    n_ok;
    logic [pli_pkg::WORD_W-1:0]   r_got,   n_got;

    // shared index stepper: one adder and one compare serve both shift directions
    logic                         step_down;
    logic [pli_pkg::CNT_W-1:0]    step_sum;
    logic [pli_pkg::CNT_W-1:0]    cmp_lhs;
    logic [pli_pkg::CNT_W-1:0]    cmp_rhs;
    logic                         cmp_gt;

    // decode helpers
    logic [pli_pkg::CNT_W-1:0]    pos_m1;
    logic                         not_full;
    logic                         pos_in_list;

    always_comb begin
        step_sum = r_idx + (step_down ? {pli_pkg::CNT_W{1'b1}} : CNT_ONE);
        cmp_gt   = cmp_lhs > cmp_rhs;
    end

    assign pos_m1      = pli_pkg::CNT_W'(i_item.position) - CNT_ONE;
    assign not_full    = r_count < CNT_FULL;
    assign pos_in_list = (i_item.position != '0)
                      && (pli_pkg::CNT_W'(i_item.position) <= r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pli_pkg::ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_slot <= n_slot;
        r_word <= n_word;
        r_ok   <= n_ok;
        r_got  <= n_got;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_slot      = r_slot;
        n_word      = r_word;
        n_ok        = r_ok;
        n_got       = r_got;
        step_down   = 1'b0;
        cmp_lhs     = r_idx;
        cmp_rhs     = r_slot;
        o_ram       = '0;
        o_res_valid = 1'b0;

        case (r_state)
            pli_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_word = i_item.item_value;
                    n_got  = '0;
                    n_ok   = 1'b0;
                    n_slot = '0;
                    n_state = pli_pkg::ST_DONE;
                    case (pli_pkg::t_opcode'(i_item.opcode))
                        pli_pkg::OP_INS_FRONT, pli_pkg::OP_INS_LAST,
                        pli_pkg::OP_INS_AT: begin
                            if (i_item.opcode == pli_pkg::OP_INS_FRONT) begin
                                n_slot = '0;
                                n_ok   = not_full;
                            end else if (i_item.opcode == pli_pkg::OP_INS_LAST) begin
                                n_slot = r_count;
                                n_ok   = not_full;
                            end else begin
                                n_slot = pos_m1;
                                n_ok   = not_full && (i_item.position != '0)
                                      && (pos_m1 <= r_count);
                            end
                            n_idx = r_count;
                            if (n_ok) begin
                                n_state = pli_pkg::ST_UP_RD;
                            end
                        end
                        pli_pkg::OP_DEL_FIRST, pli_pkg::OP_DEL_LAST,
                        pli_pkg::OP_DEL_AT: begin
                            if (i_item.opcode == pli_pkg::OP_DEL_FIRST) begin
                                n_slot = '0;
                                n_ok   = r_count != '0;
                            end else if (i_item.opcode == pli_pkg::OP_DEL_LAST) begin
                                n_slot = r_count - CNT_ONE;
                                n_ok   = r_count != '0;
                            end else begin
                                n_slot = pos_m1;
                                n_ok   = pos_in_list;
                            end
                            n_idx = n_slot;
                            if (n_ok) begin
                                n_state = pli_pkg::ST_DN_RD;
                            end
                        end
                        pli_pkg::OP_READ_AT: begin
                            n_slot = pos_m1;
                            n_ok   = pos_in_list;
                            if (pos_in_list) begin
                                n_state = pli_pkg::ST_RD_ADDR;
                            end
                        end
                        default: begin
                            n_ok = 1'b0;
                        end
                    endcase
                end
            end

            // open a gap: move entry idx-1 up to idx until idx reaches the slot
            pli_pkg::ST_UP_RD: begin
                step_down = 1'b1;
                cmp_lhs   = r_idx;
                cmp_rhs   = r_slot;
                if (cmp_gt) begin
                    o_ram.raddr = step_sum[pli_pkg::ADDR_W-1:0];
                    n_state     = pli_pkg::ST_UP_WR;
                end else begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_slot[pli_pkg::ADDR_W-1:0];
                    o_ram.wdata = r_word;
                    n_count     = r_count + CNT_ONE;
                    n_state     = pli_pkg::ST_DONE;
                end
            end

            pli_pkg::ST_UP_WR: begin
                step_down   = 1'b1;
                o_ram.we    = 1'b1;
                o_ram.waddr = r_idx[pli_pkg::ADDR_W-1:0];
                o_ram.wdata = i_rdata;
                n_idx       = step_sum;
                n_state     = pli_pkg::ST_UP_RD;
            end

            // close the gap: move entry idx+1 down to idx while idx+1 < count
            pli_pkg::ST_DN_RD: begin
                step_down = 1'b0;
                cmp_lhs   = r_count;
                cmp_rhs   = step_sum;
                if (cmp_gt) begin
                    o_ram.raddr = step_sum[pli_pkg::ADDR_W-1:0];
                    n_state     = pli_pkg::ST_DN_WR;
                end else begin
                    n_count = r_count - CNT_ONE;
                    n_state = pli_pkg::ST_DONE;
                end
            end

            pli_pkg::ST_DN_WR: begin
                step_down   = 1'b0;
                o_ram.we    = 1'b1;
                o_ram.waddr = r_idx[pli_pkg::ADDR_W-1:0];
                o_ram.wdata = i_rdata;
                n_idx       = step_sum;
                n_state     = pli_pkg::ST_DN_RD;
            end

            pli_pkg::ST_RD_ADDR: begin
                o_ram.raddr = r_slot[pli_pkg::ADDR_W-1:0];
                n_state     = pli_pkg::ST_RD_DATA;
            end

            pli_pkg::ST_RD_DATA: begin
                n_got   = i_rdata;
                n_state = pli_pkg::ST_DONE;
            end

            pli_pkg::ST_DONE: begin
                o_res_valid = i_out_free;
                if (i_out_free) begin
                    n_state = pli_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = pli_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy            = r_state != pli_pkg::ST_IDLE;
    assign o_res.ok          = r_ok;
    assign o_res.entry_total = r_count;
    assign o_res.read_value  = r_got;

endmodule

// ===== src/positional_list_insert_delete.sv =====
// ----------------------------------------------------------------------------
// positional_list_insert_delete
// Ordered list of up to 16 signed words with insert, delete and read by place.
// ----------------------------------------------------------------------------
// One input beat is one operation (insert at front, end or 1-based position,
// delete first, last or at position, read at position); every beat returns
// exactly one output beat with a success flag, the entry count afterwards and
// the word read (zero unless a read succeeded). Entries live in one RAM with a
// single write port and a registered read port, and a shift moves one entry
// at a time (read, then write). The input stays stalled while an operation
// runs, and also while its result waits for the output register to drain. An
// insert or delete moves at most 15 entries. The input is taken again as soon
// as the result sits in the output register.
module positional_list_insert_delete (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  pli_pkg::t_in_beat    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output pli_pkg::t_out_beat   o_out_data
);

    logic                         in_accept;
    logic                         out_free;
    logic                         seq_busy;
    pli_pkg::t_ram_req            ram_req;
    logic [pli_pkg::WORD_W-1:0]   ram_rdata;
    logic                         res_valid;
    pli_pkg::t_out_beat           res;

    logic                         r_out_valid;
    pli_pkg::t_out_beat           r_out_data;

    // take a beat only while the sequencer sits idle
    assign in_accept  = i_in_valid && !seq_busy;
    assign o_in_stall = seq_busy;

    // the output register frees when empty or when its beat leaves this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    pli_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_accept),
        .i_item      (i_in_data),
        .i_out_free  (out_free),
        .i_rdata     (ram_rdata),
        .o_busy      (seq_busy),
        .o_ram       (ram_req),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    pli_ram #(
        .WIDTH (pli_pkg::WORD_W),
        .DEPTH (pli_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    // output register: load a finished result, drop the valid once it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== src/pli_checker.sv =====
// ----------------------------------------------------------------------------
// pli_checker
// Port-level checks for the positional list, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pli_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 o_in_stall,
    input  pli_pkg::t_in_beat    i_in_data,
    input  logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  pli_pkg::t_out_beat   o_out_data
);

    localparam logic [pli_pkg::CNT_W-1:0] CNT_FULL = pli_pkg::CNT_W'(pli_pkg::DEPTH);

    // the count never passes the list depth
    `PLI_ASSERT_NOW(a_total_bound, i_clk, i_rst_n, o_out_valid,
        o_out_data.entry_total <= CNT_FULL, "entry count above depth")

    // a refused operation reads back zero
    `PLI_ASSERT_NOW(a_refused_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.ok,
        o_out_data.read_value == '0, "refused beat carries a read value")

    // an accepted beat keeps the input stalled in the next cycle
    `PLI_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall,
        o_in_stall, "input open right after an accept")

    // a stalled result holds
    `PLI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_data), "stalled output beat changed")

endmodule

bind positional_list_insert_delete pli_checker u_pli_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== tb/sv/positional_list_insert_delete_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_insert_delete_tb
// Self-checking bench for the positional list (insert, delete, read by place).
// ----------------------------------------------------------------------------
// A shadow copy of the list, kept in a scoreboard class, predicts the reply to
// every operation beat the block accepts. Each reply beat is compared field by
// field with the oldest prediction. A short directed sequence covers empty-list
// refusals, bad positions, the unused opcode and extreme words. A long random
// sequence then swings the list between empty and full, with random idle
// bursts on the input and stall bursts on the output.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_tb;
    import pli_pkg::*;

    // Opcode 3'd7 has no name in the package; the block must refuse it.
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    localparam int RANDOM_OPS  = 750;
    localparam int CALM_FROM   = 600;     // no idling or stalls from this op on
    localparam int HOLD_OFF    = 40;      // cycles to watch for stray replies
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow list plus the queue of replies still owed by the block
    // ------------------------------------------------------------------------
    class list_scoreboard;
        logic signed [WORD_W-1:0] words [DEPTH];
        int unsigned              used;
        t_out_beat                expected_replies [$];
        int unsigned              failures;

        function new();
            used     = 0;
            failures = 0;
            foreach (words[i]) words[i] = '0;
        endfunction

        // Open a hole at slot and drop the word into it.
        function bit place(int unsigned slot, logic signed [WORD_W-1:0] word);
            int unsigned i;
            if (used >= DEPTH || slot > used) return 1'b0;
            for (i = used; i > slot; i--) words[i] = words[i - 1];
            words[slot] = word;
            used++;
            return 1'b1;
        endfunction

        // Close the gap left by slot.
        function bit remove(int unsigned slot);
            int unsigned i;
            if (slot >= used) return 1'b0;
            for (i = slot; i + 1 < used; i++) words[i] = words[i + 1];
            used--;
            return 1'b1;
        endfunction

        // Apply one accepted operation to the shadow list and queue its reply.
        function void note_op(t_in_beat op_beat);
            t_out_beat   reply;
            int unsigned pos;
            reply = '0;
            pos   = op_beat.position;
            case (op_beat.opcode)
                OP_INS_FRONT: reply.ok = place(0, op_beat.item_value);
                OP_INS_LAST:  reply.ok = place(used, op_beat.item_value);
                OP_INS_AT:    if (pos != 0) reply.ok = place(pos - 1, op_beat.item_value);
                OP_DEL_FIRST: reply.ok = remove(0);
                OP_DEL_LAST:  if (used != 0) reply.ok = remove(used - 1);
                OP_DEL_AT:    if (pos != 0) reply.ok = remove(pos - 1);
                OP_READ_AT: begin
                    if (pos != 0 && pos <= used) begin
                        reply.ok         = 1'b1;
                        reply.read_value = words[pos - 1];
                    end
                end
                default: ;
            endcase
            reply.entry_total = CNT_W'(used);
            expected_replies.push_back(reply);
        endfunction

        function void check_reply(t_out_beat got);
            t_out_beat want;
            if (expected_replies.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: unexpected reply ok=%0b total=%0d value=%0d",
                             $time, got.ok, got.entry_total, got.read_value);
                return;
            end
            want = expected_replies.pop_front();
            if (got.ok !== want.ok || got.entry_total !== want.entry_total ||
                got.read_value !== want.read_value) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display({"%0t: reply mismatch, expected ok=%0b total=%0d value=%0d,",
                              " got ok=%0b total=%0d value=%0d"},
                             $time, want.ok, want.entry_total, want.read_value,
                             got.ok, got.entry_total, got.read_value);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block
    // ------------------------------------------------------------------------
    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_beat  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_beat out_data;

    list_scoreboard sb;
    bit             calm    = 1'b0;   // set for the closing stretch of the run
    bit             filling = 1'b1;   // random ops lean toward inserts when set
    int unsigned    cycles  = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    positional_list_insert_delete dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // ------------------------------------------------------------------------
    // Watchdog: give up if the run takes far longer than the slowest good run
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Output side: stall in random bursts, check every reply beat taken
    // ------------------------------------------------------------------------
    initial begin
        int unsigned burst;
        forever begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 16);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Values read right after the edge are the ones the block saw at the edge.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_reply(out_data);
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Present one operation beat and hold it until the block takes it. An
    // optional idle burst drops valid first, so valid never bounces in a step.
    task automatic send_op(logic [OP_W-1:0] op, logic signed [WORD_W-1:0] word,
                           logic [POS_W-1:0] pos);
        int unsigned gap;
        t_in_beat    beat;
        if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        beat.opcode     = op;
        beat.item_value = word;
        beat.position   = pos;
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_op(in_data);
    endtask

    // Drop valid and hold off until every owed reply has come back.
    task automatic wait_for_replies();
        in_valid <= 1'b0;
        while (sb.expected_replies.size() != 0) @(posedge clk);
    endtask

    // Pick one operation. Mode flips only at an extreme, so the list keeps
    // running all the way to full and back down to empty. Most positions are
    // in range for the current size; a tenth are any 5-bit value.
    task automatic send_random_op();
        int unsigned      roll;
        int unsigned      room;
        int unsigned      ins_cut;
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        room = sb.used;
        if (filling) begin
            if (room == DEPTH && $urandom_range(0, 5) == 0) filling = 1'b0;
        end else begin
            if (room == 0 && $urandom_range(0, 5) == 0) filling = 1'b1;
        end
        ins_cut = filling ? 68 : 28;
        roll    = $urandom_range(0, 99);
        if (roll < 3) begin
            op = OP_UNUSED;
        end else if (roll < ins_cut) begin
            case ($urandom_range(0, 2))
                0:       op = OP_INS_FRONT;
                1:       op = OP_INS_LAST;
                default: op = OP_INS_AT;
            endcase
        end else if (roll < 90) begin
            case ($urandom_range(0, 2))
                0:       op = OP_DEL_FIRST;
                1:       op = OP_DEL_LAST;
                default: op = OP_DEL_AT;
            endcase
        end else begin
            op = OP_READ_AT;
        end
        if ($urandom_range(0, 9) == 0)
            pos = POS_W'($urandom_range(0, 31));
        else if (op == OP_INS_AT)
            pos = POS_W'($urandom_range(1, room + 1));
        else
            pos = POS_W'($urandom_range(1, (room == 0) ? 1 : room));
        send_op(op, $urandom, pos);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list: every delete and read is refused.
        send_op(OP_READ_AT,   32'sd0, 5'd1);
        send_op(OP_DEL_FIRST, 32'sd0, 5'd0);
        send_op(OP_DEL_LAST,  32'sd0, 5'd0);
        send_op(OP_DEL_AT,    32'sd0, 5'd1);
        // Insert position zero and one past the end plus one are refused.
        send_op(OP_INS_AT,    32'sh0000_1234, 5'd0);
        send_op(OP_INS_AT,    32'sh0000_1234, 5'd2);
        // Build the list from extreme words through every insert flavor.
        send_op(OP_INS_AT,    32'sh7FFF_FFFF, 5'd1);
        send_op(OP_INS_FRONT, 32'sh8000_0000, 5'd17);
        send_op(OP_INS_LAST,  32'sh0000_0000, 5'd31);
        send_op(OP_INS_AT,    32'shFFFF_FFFF, 5'd4);   // right after the last
        send_op(OP_INS_AT,    32'sh5555_5555, 5'd2);
        // Reads at both ends, at zero and past the end.
        send_op(OP_READ_AT,   32'sd0, 5'd5);
        send_op(OP_READ_AT,   32'sd0, 5'd1);
        send_op(OP_READ_AT,   32'sd0, 5'd0);
        send_op(OP_READ_AT,   32'sd0, 5'd6);
        send_op(OP_READ_AT,   32'shAAAA_AAAA, 5'd31);
        send_op(OP_UNUSED,    32'sd1, 5'd1);
        // Deletes: bad positions first, then the middle and both ends.
        send_op(OP_DEL_AT,    32'sd0, 5'd0);
        send_op(OP_DEL_AT,    32'sd0, 5'd6);
        send_op(OP_DEL_AT,    32'sd0, 5'd3);
        send_op(OP_DEL_FIRST, 32'sd0, 5'd0);
        send_op(OP_DEL_LAST,  32'sd0, 5'd0);
        send_op(OP_READ_AT,   32'sd0, 5'd2);
        wait_for_replies();

        for (int i = 0; i < RANDOM_OPS; i++) begin
            if (i == RANDOM_OPS / 2) wait_for_replies();
            if (i == CALM_FROM) calm = 1'b1;
            send_random_op();
        end

        wait_for_replies();
        repeat (HOLD_OFF) @(posedge clk);
        if (sb.failures == 0 && sb.expected_replies.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/pli_pkg.sv
src/pli_ram.sv
src/pli_seq.sv
src/positional_list_insert_delete.sv
src/pli_checker.sv
tb/sv/positional_list_insert_delete_tb.sv
